// ----- design/geq_pkg.sv -----
// Shared types and constants for the graphic equalizer band bank.
package geq_pkg;

   localparam int MAX_BANDS     = 32;
   localparam int CHAN_LIMIT    = 16;
   localparam int BAND_BITS     = $clog2(MAX_BANDS);
   localparam int CHAN_BITS     = $clog2(CHAN_LIMIT);
   localparam int SLOT_BITS     = BAND_BITS + CHAN_BITS;
   localparam int NB_BITS       = BAND_BITS + 1;
   localparam int NCH_BITS      = CHAN_BITS + 1;

   localparam int SAMPLE_WIDTH  = 24;
   localparam int COEF_WIDTH    = 24;
   localparam int GAIN_WIDTH    = 24;
   localparam int GAIN_FRAC     = 20;
   localparam int COEF_FRAC     = COEF_WIDTH - 3;
   localparam int XH_BITS       = SAMPLE_WIDTH + 4;
   localparam int YH_BITS       = SAMPLE_WIDTH + 8;
   localparam int HIST_BITS     = 2 * XH_BITS + 2 * YH_BITS;

   localparam int MUL_A_BITS    = GAIN_WIDTH + 1;
   localparam int MUL_B_BITS    = YH_BITS + 1;
   localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
   localparam int SUM_BITS      = PROD_BITS + 2;
   localparam int ACC_BITS      = PROD_BITS + BAND_BITS + 1;

   localparam int ACTION_BITS   = 3;
   localparam int CH_FIELD_BITS = 4;
   localparam int BD_FIELD_BITS = 5;
   localparam int NUM_BANDS_BITS    = 6;
   localparam int NUM_CHANNELS_BITS = 5;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 6;

   localparam logic [NUM_BANDS_BITS-1:0]    NUM_BANDS_RESET    = 6'd10;
   localparam logic [NUM_CHANNELS_BITS-1:0] NUM_CHANNELS_RESET = 5'd2;

   localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_COEF   = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_GAIN   = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_PREAMP = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_BANDS    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_CHANNELS = 1'd1;

   typedef struct packed {
      logic [ACTION_BITS-1:0]          action;
      logic                            first_of_buffer;
      logic signed [SAMPLE_WIDTH-1:0]  sample_in;
      logic [CH_FIELD_BITS-1:0]        channel;
      logic [BD_FIELD_BITS-1:0]        band;
      logic signed [COEF_WIDTH-1:0]    diff_coef;
      logic signed [COEF_WIDTH-1:0]    fb1_coef;
      logic signed [COEF_WIDTH-1:0]    fb2_coef;
      logic [GAIN_WIDTH-1:0]           gain_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0]  sample_out;
      logic [CH_FIELD_BITS-1:0]        out_channel;
      logic                            clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [XH_BITS-1:0] xh1;
      logic signed [XH_BITS-1:0] xh2;
      logic signed [YH_BITS-1:0] yh1;
      logic signed [YH_BITS-1:0] yh2;
   } hist_type;

endpackage

// ----- design/geq_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module geq_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem_ff [2**ADDR_BITS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/geq_mul.sv -----
// Shared signed multiplier with registered product.
module geq_mul (
   input  logic                                  clock,
   input  logic signed [geq_pkg::MUL_A_BITS-1:0] mul_a,
   input  logic signed [geq_pkg::MUL_B_BITS-1:0] mul_b,
   output logic signed [geq_pkg::PROD_BITS-1:0]  prod
);
   import geq_pkg::*;

   logic signed [PROD_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;
endmodule

// ----- design/graphic_equalizer_band_bank.sv -----
// Top level: sequencer, coefficient registers and history/gain memories of the band bank.
//
//  channel | beat signals                 | moves
//  req     | req_valid req_stall req_data | one sample, coefficient/gain load or clear
//  rsp     | rsp_valid rsp_stall rsp_data | one equalized sample per sample beat
//  csr     | csr_write_enable csr_index   | num_bands, num_channels writes
//
// A sample steps through ST_PRE and ST_XSCALE, ST_T0 to ST_T4 for each band, then ST_ACC
// and ST_OUT (from ST_XSCALE straight to ST_OUT with no active bands); one shared multiplier
// forms all products. Loads are taken in ST_IDLE; a clear request zeroes only the history.
// After reset a pass over all 512 entries zeroes the history and band gain memories; req is
// stalled meanwhile. The result sits in an output register, so a stalled rsp only
// holds the block when the next result is ready.
module graphic_equalizer_band_bank (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  geq_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output geq_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [geq_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [geq_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   import geq_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PRE, ST_XSCALE,
      ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_ACC, ST_OUT
   } state_type;

   state_type                        state_ff, state_in;
   logic [SLOT_BITS-1:0]             clr_cnt_ff, clr_cnt_in;
   logic                             clr_all_ff, clr_all_in;
   logic [NUM_BANDS_BITS-1:0]        num_bands_ff;
   logic [NUM_CHANNELS_BITS-1:0]     num_channels_ff;
   logic [CHAN_BITS-1:0]             ctr_ff, ctr_in;
   logic [CHAN_BITS-1:0]             ch_ff, ch_in;
   logic [NB_BITS-1:0]               nb_ff, nb_in;
   logic [NB_BITS-1:0]               band_ff, band_in;
   logic signed [SAMPLE_WIDTH-1:0]   sample_ff, sample_in_r;
   logic signed [XH_BITS-1:0]        x_ff, x_in;
   logic signed [SUM_BITS-1:0]       s_ff, s_in;
   logic signed [YH_BITS-1:0]        y_ff, y_in;
   logic signed [ACC_BITS-1:0]       acc_ff, acc_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rsp_type                          rsp_ff, rsp_in;

   logic signed [COEF_WIDTH-1:0]     diff_ff [MAX_BANDS];
   logic signed [COEF_WIDTH-1:0]     fb1_ff [MAX_BANDS];
   logic signed [COEF_WIDTH-1:0]     fb2_ff [MAX_BANDS];
   logic [GAIN_WIDTH-1:0]            preamp_ff [CHAN_LIMIT];

   logic signed [MUL_A_BITS-1:0]     mul_a;
   logic signed [MUL_B_BITS-1:0]     mul_b;
   logic signed [PROD_BITS-1:0]      prod;

   logic                             hist_we, hist_re;
   logic [SLOT_BITS-1:0]             hist_waddr, hist_raddr;
   logic [HIST_BITS-1:0]             hist_wdata, hist_rdata;
   hist_type                         hist_q, hist_w;
   logic                             gain_we;
   logic [SLOT_BITS-1:0]             gain_waddr;
   logic [GAIN_WIDTH-1:0]            gain_wdata, gain_q;

   logic                             accept;
   logic [NCH_BITS-1:0]              nch_eff;
   logic [CHAN_BITS-1:0]             ch_sel;
   logic [NCH_BITS-1:0]              ch_next;
   logic [BAND_BITS-1:0]             band_idx;
   logic [NB_BITS-1:0]               band_inc;
   logic signed [XH_BITS:0]          xdiff;
   logic signed [PROD_BITS-1:0]      xr;
   logic signed [SUM_BITS-1:0]       yd, yr;
   logic signed [ACC_BITS-1:0]       rr;
   logic                             x_fits, y_fits, r_fits;

   assign hist_q   = hist_type'(hist_rdata);
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign band_idx = band_ff[BAND_BITS-1:0];
   assign band_inc = band_ff + NB_BITS'(1);

   // channel selection for an incoming sample
   always_comb begin
      if (num_channels_ff == '0) begin
         nch_eff = NCH_BITS'(1);
      end else if (num_channels_ff > NUM_CHANNELS_BITS'(CHAN_LIMIT)) begin
         nch_eff = NCH_BITS'(CHAN_LIMIT);
      end else begin
         nch_eff = NCH_BITS'(num_channels_ff);
      end
      ch_sel = req_data.first_of_buffer ? '0 : ctr_ff;
      if ({1'b0, ch_sel} >= nch_eff) begin
         ch_sel = '0;
      end
      ch_next = {1'b0, ch_sel} + NCH_BITS'(1);
      if (ch_next >= nch_eff) begin
         ch_next = '0;
      end
   end

   // rounding and saturation paths
   always_comb begin
      xdiff  = {x_ff[XH_BITS-1], x_ff} - {hist_q.xh2[XH_BITS-1], hist_q.xh2};
      xr     = (prod + (PROD_BITS'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
      x_fits = (&xr[PROD_BITS-1:XH_BITS-1]) || !(|xr[PROD_BITS-1:XH_BITS-1]);
      yd     = s_ff - {{(SUM_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
      yr     = yd >>> COEF_FRAC;
      y_fits = (&yr[SUM_BITS-1:YH_BITS-1]) || !(|yr[SUM_BITS-1:YH_BITS-1]);
      rr     = (acc_ff + (ACC_BITS'(1) <<< GAIN_FRAC)) >>> (GAIN_FRAC + 1);
      r_fits = (&rr[ACC_BITS-1:SAMPLE_WIDTH-1]) || !(|rr[ACC_BITS-1:SAMPLE_WIDTH-1]);
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PRE: begin
            mul_a = {1'b0, preamp_ff[ch_ff]};
            mul_b = {{(MUL_B_BITS-SAMPLE_WIDTH){sample_ff[SAMPLE_WIDTH-1]}}, sample_ff};
         end
         ST_T0: begin
            mul_a = {{(MUL_A_BITS-COEF_WIDTH){diff_ff[band_idx][COEF_WIDTH-1]}},
                     diff_ff[band_idx]};
            mul_b = {{(MUL_B_BITS-XH_BITS-1){xdiff[XH_BITS]}}, xdiff};
         end
         ST_T1: begin
            mul_a = {{(MUL_A_BITS-COEF_WIDTH){fb1_ff[band_idx][COEF_WIDTH-1]}},
                     fb1_ff[band_idx]};
            mul_b = {{(MUL_B_BITS-YH_BITS){hist_q.yh1[YH_BITS-1]}}, hist_q.yh1};
         end
         ST_T2: begin
            mul_a = {{(MUL_A_BITS-COEF_WIDTH){fb2_ff[band_idx][COEF_WIDTH-1]}},
                     fb2_ff[band_idx]};
            mul_b = {{(MUL_B_BITS-YH_BITS){hist_q.yh2[YH_BITS-1]}}, hist_q.yh2};
         end
         ST_T4: begin
            mul_a = {1'b0, gain_q};
            mul_b = {{(MUL_B_BITS-YH_BITS){y_ff[YH_BITS-1]}}, y_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_all_in   = clr_all_ff;
      ctr_in       = ctr_ff;
      ch_in        = ch_ff;
      nb_in        = nb_ff;
      band_in      = band_ff;
      sample_in_r  = sample_ff;
      x_in         = x_ff;
      s_in         = s_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      hist_we      = 1'b0;
      hist_waddr   = {band_idx, ch_ff};
      hist_w       = '0;
      hist_re      = 1'b0;
      hist_raddr   = {band_idx, ch_ff};
      gain_we      = 1'b0;
      gain_waddr   = {req_data.band, req_data.channel};
      gain_wdata   = req_data.gain_value;

      case (state_ff)
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_cnt_ff;
            gain_we    = clr_all_ff;
            gain_waddr = clr_cnt_ff;
            gain_wdata = '0;
            clr_cnt_in = clr_cnt_ff + SLOT_BITS'(1);
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_SAMPLE: begin
                     ch_in       = ch_sel;
                     ctr_in      = ch_next[CHAN_BITS-1:0];
                     sample_in_r = req_data.sample_in;
                     nb_in       = (num_bands_ff > NUM_BANDS_BITS'(MAX_BANDS)) ?
                                   NB_BITS'(MAX_BANDS) : NB_BITS'(num_bands_ff);
                     state_in    = ST_PRE;
                  end
                  ACT_GAIN: begin
                     gain_we = 1'b1;
                  end
                  ACT_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_all_in = 1'b0;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PRE: begin
            state_in = ST_XSCALE;
         end
         ST_XSCALE: begin
            x_in       = x_fits ? xr[XH_BITS-1:0] :
                         {xr[PROD_BITS-1], {(XH_BITS-1){~xr[PROD_BITS-1]}}};
            band_in    = '0;
            acc_in     = '0;
            hist_re    = 1'b1;
            hist_raddr = {{BAND_BITS{1'b0}}, ch_ff};
            state_in   = (nb_ff == '0) ? ST_OUT : ST_T0;
         end
         ST_T0: begin
            // product of the previous band's gain stage is pending
            if (band_ff != '0) begin
               acc_in = acc_ff + {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
            end
            state_in = ST_T1;
         end
         ST_T1: begin
            s_in = {{(SUM_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod}
                   + (SUM_BITS'(1) <<< (COEF_FRAC - 1));
            state_in = ST_T2;
         end
         ST_T2: begin
            s_in     = s_ff + {{(SUM_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
            state_in = ST_T3;
         end
         ST_T3: begin
            y_in     = y_fits ? yr[YH_BITS-1:0] :
                       {yr[SUM_BITS-1], {(YH_BITS-1){~yr[SUM_BITS-1]}}};
            state_in = ST_T4;
         end
         ST_T4: begin
            hist_we     = 1'b1;
            hist_w.xh1  = x_ff;
            hist_w.xh2  = hist_q.xh1;
            hist_w.yh1  = y_ff;
            hist_w.yh2  = hist_q.yh1;
            band_in     = band_inc;
            if (band_inc < nb_ff) begin
               hist_re    = 1'b1;
               hist_raddr = {band_inc[BAND_BITS-1:0], ch_ff};
               state_in   = ST_T0;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_in   = acc_ff + {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.sample_out  = r_fits ? rr[SAMPLE_WIDTH-1:0] :
                                    {rr[ACC_BITS-1], {(SAMPLE_WIDTH-1){~rr[ACC_BITS-1]}}};
               rsp_in.clipped     = !r_fits;
               rsp_in.out_channel = ch_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      hist_wdata = hist_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_cnt_ff      <= '0;
         clr_all_ff      <= 1'b1;
         ctr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         num_bands_ff    <= NUM_BANDS_RESET;
         num_channels_ff <= NUM_CHANNELS_RESET;
         for (int i = 0; i < MAX_BANDS; i++) begin
            diff_ff[i] <= '0;
            fb1_ff[i]  <= '0;
            fb2_ff[i]  <= '0;
         end
         for (int i = 0; i < CHAN_LIMIT; i++) begin
            preamp_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_all_ff   <= clr_all_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && csr_index == CSR_NUM_BANDS) begin
            num_bands_ff <= csr_write_data[NUM_BANDS_BITS-1:0];
         end
         if (csr_write_enable && csr_index == CSR_NUM_CHANNELS) begin
            num_channels_ff <= csr_write_data[NUM_CHANNELS_BITS-1:0];
         end
         if (accept && req_data.action == ACT_COEF) begin
            diff_ff[req_data.band] <= req_data.diff_coef;
            fb1_ff[req_data.band]  <= req_data.fb1_coef;
            fb2_ff[req_data.band]  <= req_data.fb2_coef;
         end
         if (accept && req_data.action == ACT_PREAMP) begin
            preamp_ff[req_data.channel] <= req_data.gain_value;
         end
      end
      ch_ff     <= ch_in;
      nb_ff     <= nb_in;
      band_ff   <= band_in;
      sample_ff <= sample_in_r;
      x_ff      <= x_in;
      s_ff      <= s_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
   end

   geq_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   geq_ram #(.WIDTH(HIST_BITS), .ADDR_BITS(SLOT_BITS)) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .re    (hist_re),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   geq_ram #(.WIDTH(GAIN_WIDTH), .ADDR_BITS(SLOT_BITS)) u_gain_ram (
      .clock (clock),
      .we    (gain_we),
      .waddr (gain_waddr),
      .wdata (gain_wdata),
      .re    (hist_re),
      .raddr (hist_raddr),
      .rdata (gain_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
